>>> src/cft_pkg.sv
// Package: shared types, codes and helpers for the CSV field tokenizer.
package cft_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned CfgIdxW  = 2;
    localparam logic [ByteW-1:0] NlByte       = 8'h0A;
    localparam logic [ByteW-1:0] SepResetVal  = 8'd44;
    localparam logic [ByteW-1:0] QuoteResetVal = 8'd34;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SEPARATOR = 2'd0,
        CFG_QUOTE     = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_QUOTED = 2'd2,
        MODE_QSEEN  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             end_marker;
    } t_in_item;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        t_kind            kind;
        logic             in_header;
        logic             last_result;
    } t_out_item;

    typedef struct packed {
        logic [CfgIdxW-1:0] reg_index;
        logic [ByteW-1:0]   wr_data;
    } t_cfg_item;

    // results of one item, up to two, first in res0
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  res0;
        t_out_item  res1;
    } t_step_res;

    function automatic t_out_item mk_result(input logic [ByteW-1:0] b, input t_kind k,
                                            input logic hdr);
        t_out_item r;
        r.out_byte    = (k == KIND_BYTE) ? b : '0;
        r.kind        = k;
        r.in_header   = hdr;
        r.last_result = 1'b0;
        return r;
    endfunction

endpackage

>>> src/cft_chan_if.sv
// Interface: valid/ready channel carrying one payload per transaction.
interface cft_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/cft_cfg_regs.sv
// Configuration registers: separator and quote bytes.
module cft_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cft_chan_if.sink            i_cfg,
    output logic [7:0]          o_sep,
    output logic [7:0]          o_quote
);
    import cft_pkg::*;

    logic [ByteW-1:0] r_sep;
    logic [ByteW-1:0] r_quote;
    logic [ByteW-1:0] n_sep;
    logic [ByteW-1:0] n_quote;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_sep   = r_sep;
        n_quote = r_quote;
        if (i_cfg.valid) begin
            unique case (i_cfg.payload.reg_index)
                CFG_SEPARATOR: n_sep   = i_cfg.payload.wr_data;
                CFG_QUOTE:     n_quote = i_cfg.payload.wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep   <= SepResetVal;
            r_quote <= QuoteResetVal;
        end else begin
            r_sep   <= n_sep;
            r_quote <= n_quote;
        end
    end

    assign o_sep   = r_sep;
    assign o_quote = r_quote;

endmodule

>>> src/cft_step.sv
// Parse engine: mode state and the results of the registered input byte.
module cft_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cft_pkg::t_in_item   i_item,
    input  logic                i_advance,
    input  logic [7:0]          i_sep,
    input  logic [7:0]          i_quote,
    output cft_pkg::t_step_res  o_res
);
    import cft_pkg::*;

    t_mode r_mode, n_mode;
    logic  r_rec, n_rec;
    logic  r_hdr, n_hdr;
    t_step_res res;
    logic [ByteW-1:0] b;

    assign b = i_item.data_byte;

    always_comb begin
        n_mode   = r_mode;
        n_rec    = r_rec;
        n_hdr    = r_hdr;
        res.cnt  = 2'd0;
        res.res0 = mk_result('0, KIND_BYTE, r_hdr);
        res.res1 = mk_result('0, KIND_BYTE, r_hdr);
        if (i_item.end_marker) begin
            if (r_mode == MODE_QUOTED) begin
                res.res0 = mk_result('0, KIND_ERROR, r_hdr);
                res.cnt  = 2'd1;
            end else if (r_rec || r_mode != MODE_START) begin
                res.res0 = mk_result('0, KIND_RECORD, r_hdr);
                res.cnt  = 2'd1;
            end
            n_mode = MODE_START;
            n_rec  = 1'b0;
            n_hdr  = 1'b1;
        end else begin
            unique case (r_mode)
                MODE_START, MODE_PLAIN: begin
                    if (b == NlByte) begin
                        res.res0 = mk_result('0, KIND_RECORD, r_hdr);
                        res.cnt  = 2'd1;
                        n_hdr    = 1'b0;
                        n_rec    = 1'b0;
                        n_mode   = MODE_START;
                    end else if (b == i_sep) begin
                        res.res0 = mk_result('0, KIND_FIELD, r_hdr);
                        res.cnt  = 2'd1;
                        n_rec    = 1'b1;
                        n_mode   = MODE_START;
                    end else if (r_mode == MODE_START && b == i_quote) begin
                        n_rec  = 1'b1;
                        n_mode = MODE_QUOTED;
                    end else begin
                        res.res0 = mk_result(b, KIND_BYTE, r_hdr);
                        res.cnt  = 2'd1;
                        n_rec    = 1'b1;
                        n_mode   = MODE_PLAIN;
                    end
                end
                MODE_QUOTED: begin
                    if (b == i_quote) begin
                        n_mode = MODE_QSEEN;
                    end else begin
                        res.res0 = mk_result(b, KIND_BYTE, r_hdr);
                        res.cnt  = 2'd1;
                    end
                end
                MODE_QSEEN: begin
                    if (b == i_quote) begin
                        res.res0 = mk_result(b, KIND_BYTE, r_hdr);
                        res.cnt  = 2'd1;
                        n_mode   = MODE_QUOTED;
                    end else if (b == NlByte) begin
                        res.res0 = mk_result('0, KIND_RECORD, r_hdr);
                        res.cnt  = 2'd1;
                        n_hdr    = 1'b0;
                        n_rec    = 1'b0;
                        n_mode   = MODE_START;
                    end else if (b == i_sep) begin
                        res.res0 = mk_result('0, KIND_FIELD, r_hdr);
                        res.cnt  = 2'd1;
                        n_mode   = MODE_START;
                    end else begin
                        // stray quote: emit it as content, stay quoted
                        res.res0 = mk_result(i_quote, KIND_BYTE, r_hdr);
                        res.res1 = mk_result(b, KIND_BYTE, r_hdr);
                        res.cnt  = 2'd2;
                        n_mode   = MODE_QUOTED;
                    end
                end
                default: ;
            endcase
        end
        if (res.cnt == 2'd2) begin
            res.res1.last_result = 1'b1;
        end else if (res.cnt == 2'd1) begin
            res.res0.last_result = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
            r_rec  <= 1'b0;
            r_hdr  <= 1'b1;
        end else if (i_advance) begin
            r_mode <= n_mode;
            r_rec  <= n_rec;
            r_hdr  <= n_hdr;
        end
    end

    assign o_res = res;

    a_err_only_quoted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && res.cnt != 2'd0 && res.res0.kind == KIND_ERROR)
            |-> (r_mode == MODE_QUOTED && i_item.end_marker))
        else $error("error result outside quoted field");

    a_hdr_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_item.end_marker) |=> (r_hdr && !r_rec && r_mode == MODE_START))
        else $error("state not restored after end marker");

    a_pair_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.cnt == 2'd2) |-> (r_mode == MODE_QSEEN && !i_item.end_marker))
        else $error("two results outside quote-seen mode");

endmodule

>>> src/cft_out_buf.sv
// Result register: holds up to two results of one item and presents them in order.
module cft_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  cft_pkg::t_step_res  i_step,
    output logic                o_free,
    cft_chan_if.source          o_out
);
    import cft_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_out_item  r_res0, n_res0;
    t_out_item  r_res1, n_res1;
    logic       pop;

    assign pop    = o_out.valid && o_out.ready;
    assign o_free = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);

    always_comb begin
        n_cnt  = r_cnt;
        n_res0 = r_res0;
        n_res1 = r_res1;
        if (i_load) begin
            n_cnt  = i_step.cnt;
            n_res0 = i_step.res0;
            n_res1 = i_step.res1;
        end else if (pop) begin
            if (r_cnt == 2'd2) begin
                n_cnt  = 2'd1;
                n_res0 = r_res1;
            end else begin
                n_cnt = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

    assign o_out.valid   = (r_cnt != 2'd0);
    assign o_out.payload = r_res0;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result count out of range");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (!r_res0.last_result && r_res1.last_result))
        else $error("last flag misplaced in result pair");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> r_res0.last_result)
        else $error("lone result without last flag");

    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.kind != KIND_BYTE) |-> (o_out.payload.out_byte == '0))
        else $error("marker result carries a byte");

endmodule

>>> src/csv_field_tokenizer.sv
// Top level: CSV field tokenizer, one text byte per transaction.
//
//  channel  dir  payload                                      handshake
//  i_in     in   data_byte, end_marker                        valid/ready
//  o_out    out  out_byte, kind, in_header, last_result       valid/ready
//  i_cfg    in   reg_index, wr_data (0 separator, 1 quote)    valid/ready, always ready
//
// Input register, one level of parse logic, result register: one byte per cycle
// while o_out is ready; a stray quote's two results stall input until both are taken.
// Items with no result pass through without using an output cycle.
// Synchronous active-low reset: comma separator, double quote, header state.
// o_out stalls back-pressure i_in once the input register is full.
module csv_field_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cft_chan_if.sink   i_in,
    cft_chan_if.source o_out,
    cft_chan_if.sink   i_cfg
);
    import cft_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      out_free;
    logic      advance;
    logic [ByteW-1:0] sep;
    logic [ByteW-1:0] quote;
    t_step_res step;

    assign advance     = r_in_valid && out_free;
    assign i_in.ready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.payload;
        end
    end

    cft_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_sep   (sep),
        .o_quote (quote)
    );

    cft_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (r_in_item),
        .i_advance (advance),
        .i_sep     (sep),
        .i_quote   (quote),
        .o_res     (step)
    );

    cft_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && step.cnt != 2'd0),
        .i_step  (step),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule
